// File: rtl/core/led_strip_frame_streamer_unit_macros.svh
// ----------------------------------------------------------------------------
// LED strip streamer assertion macros
// Shared concurrent assertion forms, sampled on clk and held off during reset.
// ----------------------------------------------------------------------------
`ifndef LED_STRIP_FRAME_STREAMER_UNIT_MACROS_SVH
`define LED_STRIP_FRAME_STREAMER_UNIT_MACROS_SVH

// Same-cycle implication.
`define LSFS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define LSFS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/lsfs_pkg.sv
// ----------------------------------------------------------------------------
// LED strip streamer package
// Field widths, request codes and defaults shared by the streamer files.
// ----------------------------------------------------------------------------
package lsfs_pkg;

  localparam int NUM_LEDS_DEF = 160;
  localparam int REQ_W        = 2;
  localparam int IDX_W        = 8;
  localparam int COMP_W       = 7;
  localparam int WHEEL_W      = 9;
  localparam int BYTE_W       = 8;

  // Pixel index is 8 bits wide, so at most this many LEDs can ever be written.
  localparam int MAX_IDX_ROWS = 1 << IDX_W;

  typedef enum logic [REQ_W-1:0] {
    REQ_RGB   = 2'd0,
    REQ_WHEEL = 2'd1,
    REQ_SHOW  = 2'd2,
    REQ_SLOT  = 2'd3
  } req_t;

endpackage

// File: rtl/core/lsfs_if.sv
// ----------------------------------------------------------------------------
// LED strip streamer channels
// Valid/ready request channel and byte result channel.
// ----------------------------------------------------------------------------
interface lsfs_in_if;
  import lsfs_pkg::*;

  logic               valid;
  logic               ready;
  logic [REQ_W-1:0]   req_type;
  logic [IDX_W-1:0]   pixel_index;
  logic [COMP_W-1:0]  red;
  logic [COMP_W-1:0]  green;
  logic [COMP_W-1:0]  blue;
  logic [WHEEL_W-1:0] wheel_pos;

  modport source (
    output valid, req_type, pixel_index, red, green, blue, wheel_pos,
    input  ready
  );
  modport sink (
    input  valid, req_type, pixel_index, red, green, blue, wheel_pos,
    output ready
  );
endinterface

interface lsfs_out_if;
  import lsfs_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] spi_byte;
  logic              frame_last;

  modport source (
    output valid, spi_byte, frame_last,
    input  ready
  );
  modport sink (
    input  valid, spi_byte, frame_last,
    output ready
  );
endinterface

// File: rtl/core/led_strip_frame_streamer_unit.sv
// ----------------------------------------------------------------------------
// LED strip frame streamer
// Pixel frame buffer with RGB and color-wheel writes, streamed out byte by
// byte on transmitter slots, followed by the latch zero bytes.
// ----------------------------------------------------------------------------
//
//  channel  | role   | transfer contents
//  ---------+--------+----------------------------------------------------
//  in_ch    | sink   | req_type, pixel_index, red, green, blue, wheel_pos
//  out_ch   | source | spi_byte, frame_last (one per slot while streaming)
//
//  When a frame starts or the stream moves into a new LED row of the pixel
//  memory, request transfers are held off until the synchronous read of that
//  row has returned; the memory read port sets this.
//  Reset clears per-LED written flags in flip-flops at once: no clearing pass,
//  an LED never written reads as zero bytes.
//  A stalled output register holds its byte and holds off every request
//  transfer until the sink takes it.
//
`include "led_strip_frame_streamer_unit_macros.svh"

module led_strip_frame_streamer_unit #(
  parameter int NUM_LEDS = lsfs_pkg::NUM_LEDS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  lsfs_in_if.sink    in_ch,
  lsfs_out_if.source out_ch
);
  import lsfs_pkg::*;

  // Only LEDs that a pixel index can reach get storage.
  localparam int ROWS       = (NUM_LEDS < MAX_IDX_ROWS) ? NUM_LEDS : MAX_IDX_ROWS;
  localparam int AW         = (ROWS > 1) ? $clog2(ROWS) : 1;
  // Latch bytes come in groups of three, so the latch is whole rows too.
  localparam int LATCH_ROWS = (NUM_LEDS + 63) / 64;
  localparam int TOTAL_ROWS = NUM_LEDS + LATCH_ROWS;
  localparam int RW         = $clog2(TOTAL_ROWS);
  localparam int ROW_DW     = 3 * COMP_W;

  localparam logic [RW-1:0]     LAST_ROW = RW'(TOTAL_ROWS - 1);
  localparam logic [RW-1:0]     MEM_ROWS = RW'(ROWS);
  localparam logic [1:0]        SUB_G    = 2'd0;
  localparam logic [1:0]        SUB_R    = 2'd1;
  localparam logic [1:0]        SUB_B    = 2'd2;
  localparam logic [COMP_W-1:0] COMP_MAX = {COMP_W{1'b1}};
  localparam logic [1:0]        BAND_RG  = 2'd0;
  localparam logic [1:0]        BAND_GB  = 2'd1;
  localparam logic [1:0]        BAND_BR  = 2'd2;

  // Pixel memory: one row per LED, packed {green, red, blue}.
  logic [ROW_DW-1:0] pix_mem [ROWS];
  logic [ROWS-1:0]   written_r;
  logic [ROW_DW-1:0] rd_data_r;
  logic              rd_written_r;

  // Stream position and control.
  logic          streaming_r, streaming_nxt;
  logic [RW-1:0] row_r, row_nxt;
  logic [1:0]    sub_r, sub_nxt;
  logic          data_ok_r, data_ok_nxt;

  // Output register.
  logic              out_valid_r;
  logic [BYTE_W-1:0] spi_byte_r;
  logic              frame_last_r;

  req_t              req;
  logic              in_fire, slot_fire, show_start, last_pos, in_mem, out_free;
  logic              wr_en;
  logic [AW-1:0]     wr_addr, rd_addr;
  logic [ROW_DW-1:0] wr_data;
  logic [COMP_W-1:0] wr_r, wr_g, wr_b, wk, wk_inv;
  logic [COMP_W-1:0] cur_comp;
  logic [BYTE_W-1:0] cur_byte;

  assign req        = req_t'(in_ch.req_type);
  assign out_free   = !out_valid_r || out_ch.ready;
  assign in_mem     = row_r < MEM_ROWS;
  // Hold requests off while the output is stalled or a fresh memory row is still being read.
  assign in_ch.ready = out_free && (!streaming_r || data_ok_r || !in_mem);
  assign in_fire    = in_ch.valid && in_ch.ready;
  assign slot_fire  = in_fire && (req == REQ_SLOT) && streaming_r;
  assign show_start = in_fire && (req == REQ_SHOW) && !streaming_r;
  assign last_pos   = (row_r == LAST_ROW) && (sub_r == SUB_B);

  // Pixel write: ignored while streaming or past the end of the strip.
  assign wr_en = in_fire && !streaming_r && ((req == REQ_RGB) || (req == REQ_WHEEL))
                 && (int'(in_ch.pixel_index) < NUM_LEDS);
  assign wr_addr = in_ch.pixel_index[AW-1:0];
  assign wk      = in_ch.wheel_pos[COMP_W-1:0];
  assign wk_inv  = COMP_MAX - wk;

  always_comb begin
    wr_r = '0;
    wr_g = '0;
    wr_b = '0;
    if (req == REQ_RGB) begin
      wr_r = in_ch.red;
      wr_g = in_ch.green;
      wr_b = in_ch.blue;
    end else begin
      case (in_ch.wheel_pos[WHEEL_W-1:COMP_W])
        BAND_RG: begin
          wr_r = wk_inv;
          wr_g = wk;
        end
        BAND_GB: begin
          wr_g = wk_inv;
          wr_b = wk;
        end
        BAND_BR: begin
          wr_b = wk_inv;
          wr_r = wk;
        end
        default: ; // past the wheel: all components off
      endcase
    end
  end

  assign wr_data = {wr_g, wr_r, wr_b};

  // Read the row under the stream pointer every cycle.
  assign rd_addr = in_mem ? row_r[AW-1:0] : '0;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      pix_mem[wr_addr] <= wr_data;
    end
    rd_data_r    <= pix_mem[rd_addr];
    rd_written_r <= written_r[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      written_r <= '0;
    end else if (wr_en) begin
      written_r[wr_addr] <= 1'b1;
    end
  end

  // Byte for the current slot; unwritten LEDs and latch rows give zero.
  always_comb begin
    case (sub_r)
      SUB_G:   cur_comp = rd_data_r[3*COMP_W-1:2*COMP_W];
      SUB_R:   cur_comp = rd_data_r[2*COMP_W-1:COMP_W];
      default: cur_comp = rd_data_r[COMP_W-1:0];
    endcase
    cur_byte = (in_mem && rd_written_r) ? {1'b1, cur_comp} : '0;
  end

  // Advance the stream pointer; drop back to idle after the last latch byte.
  always_comb begin
    streaming_nxt = streaming_r;
    row_nxt       = row_r;
    sub_nxt       = sub_r;
    data_ok_nxt   = 1'b1;
    if (show_start) begin
      streaming_nxt = 1'b1;
      row_nxt       = '0;
      sub_nxt       = SUB_G;
      data_ok_nxt   = 1'b0;
    end else if (slot_fire) begin
      if (sub_r == SUB_B) begin
        sub_nxt     = SUB_G;
        data_ok_nxt = 1'b0;
        if (last_pos) begin
          streaming_nxt = 1'b0;
          row_nxt       = '0;
        end else begin
          row_nxt = row_r + 1'b1;
        end
      end else begin
        sub_nxt = sub_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      streaming_r <= 1'b0;
      row_r       <= '0;
      sub_r       <= SUB_G;
      data_ok_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      streaming_r <= streaming_nxt;
      row_r       <= row_nxt;
      sub_r       <= sub_nxt;
      data_ok_r   <= data_ok_nxt;
      if (slot_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Load the output payload on each slot transfer.
  always_ff @(posedge clk) begin
    if (slot_fire) begin
      spi_byte_r   <= cur_byte;
      frame_last_r <= last_pos;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.spi_byte   = spi_byte_r;
  assign out_ch.frame_last = frame_last_r;

  `LSFS_ASSERT_NOW(a_no_write_streaming, streaming_r, !wr_en, "pixel write while streaming")
  `LSFS_ASSERT_NOW(a_row_range, 1'b1, row_r <= LAST_ROW, "stream row out of range")
  `LSFS_ASSERT_NEXT(a_last_ends, slot_fire && last_pos, !streaming_r, "stream kept after last")
  `LSFS_ASSERT_NOW(a_out_from_slot, $rose(out_valid_r), $past(slot_fire), "result without slot")

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED strip frame streamer testbench
// Drives pixel writes, show requests and byte slots through the request
// channel and checks every streamed byte against a frame-buffer predictor.
// ----------------------------------------------------------------------------
module tb;
  import lsfs_pkg::*;

  localparam int NUM_LEDS      = NUM_LEDS_DEF;
  localparam int STRIP_BYTES   = 3 * NUM_LEDS;
  localparam int LATCH_BYTES   = ((NUM_LEDS + 63) / 64) * 3;
  localparam int FRAME_BYTES   = STRIP_BYTES + LATCH_BYTES;
  localparam int ITEMS_TARGET  = 1550;
  localparam int LONG_HOLD     = 400;
  localparam int HOLD_AT_BYTES = 100;
  localparam int STALL_LIMIT   = 3000;
  localparam int TAIL_CYCLES   = 20;
  localparam int REPORT_MAX    = 10;

  // One request as the sender plans it; drain holds it back until every
  // streamed byte that is owed has arrived.
  typedef struct {
    req_t               kind;
    logic [IDX_W-1:0]   pixel_index;
    logic [COMP_W-1:0]  red;
    logic [COMP_W-1:0]  green;
    logic [COMP_W-1:0]  blue;
    logic [WHEEL_W-1:0] wheel_pos;
    bit                 drain;
  } led_req_t;

  typedef struct packed {
    logic [BYTE_W-1:0] spi_byte;
    logic              frame_last;
  } strip_byte_t;

  typedef struct packed {
    logic [COMP_W-1:0] red;
    logic [COMP_W-1:0] green;
    logic [COMP_W-1:0] blue;
  } rgb_t;

  logic clk = 1'b0;
  logic rst_n;

  lsfs_in_if  in_ch ();
  lsfs_out_if out_ch ();

  led_strip_frame_streamer_unit #(
    .NUM_LEDS(NUM_LEDS)
  ) i_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  always #5 clk = ~clk;

  // --------------------------------------------------------------------------
  // Frame-buffer predictor state
  // --------------------------------------------------------------------------
  logic [BYTE_W-1:0] strip_mem [STRIP_BYTES];
  int                frame_pos;
  bit                frame_active;

  led_req_t    req_plan[$];       // requests still to be offered
  strip_byte_t pending_bytes[$];  // streamed bytes owed by the block
  int          bytes_checked;
  int          mismatch_count;

  // Plan-side shadow of the stream, used only to shape the stimulus.
  bit plan_active;
  int plan_left;

  // Map a wheel position to its color; three 128-step bands, black above.
  function automatic rgb_t wheel_color(logic [WHEEL_W-1:0] pos);
    rgb_t              c;
    logic [COMP_W-1:0] k;
    c = '0;
    k = pos[COMP_W-1:0];
    case (pos[WHEEL_W-1:COMP_W])
      2'd0: begin
        c.red   = 7'd127 - k;
        c.green = k;
      end
      2'd1: begin
        c.green = 7'd127 - k;
        c.blue  = k;
      end
      2'd2: begin
        c.blue = 7'd127 - k;
        c.red  = k;
      end
      default: ;
    endcase
    return c;
  endfunction

  // Advance the predictor by one accepted request; queue any byte it streams.
  task automatic advance_strip(led_req_t rq);
    rgb_t        c;
    strip_byte_t b;
    int          base;
    c    = '{red: rq.red, green: rq.green, blue: rq.blue};
    base = 3 * int'(rq.pixel_index);
    case (rq.kind)
      REQ_RGB, REQ_WHEEL: begin
        if (rq.kind == REQ_WHEEL) c = wheel_color(rq.wheel_pos);
        // Drop writes while a frame streams or past the end of the strip.
        if (!frame_active && rq.pixel_index < NUM_LEDS) begin
          strip_mem[base]     = {1'b1, c.green};
          strip_mem[base + 1] = {1'b1, c.red};
          strip_mem[base + 2] = {1'b1, c.blue};
        end
      end
      REQ_SHOW: begin
        if (!frame_active) begin
          frame_active = 1'b1;
          frame_pos    = 0;
        end
      end
      default: begin
        if (frame_active) begin
          b.spi_byte   = (frame_pos < STRIP_BYTES) ? strip_mem[frame_pos] : '0;
          b.frame_last = (frame_pos + 1 >= FRAME_BYTES);
          pending_bytes.push_back(b);
          if (b.frame_last) begin
            frame_active = 1'b0;
            frame_pos    = 0;
          end else begin
            frame_pos++;
          end
        end
      end
    endcase
  endtask

  task automatic flag_mismatch(string what, strip_byte_t want, strip_byte_t got);
    mismatch_count++;
    if (mismatch_count <= REPORT_MAX)
      $display("mismatch (%s) at %0t: expected byte %02h last %0b, got byte %02h last %0b",
               what, $time, want.spi_byte, want.frame_last, got.spi_byte, got.frame_last);
  endtask

  // --------------------------------------------------------------------------
  // Stimulus planning
  // --------------------------------------------------------------------------
  function automatic led_req_t make_req(req_t kind, int idx, int r, int g, int b, int pos);
    led_req_t q;
    q.kind        = kind;
    q.pixel_index = IDX_W'(idx);
    q.red         = COMP_W'(r);
    q.green       = COMP_W'(g);
    q.blue        = COMP_W'(b);
    q.wheel_pos   = WHEEL_W'(pos);
    q.drain       = 1'b0;
    return q;
  endfunction

  // Random payload in every field; writes mostly land on the strip and
  // wheel positions mostly fall in the colored bands.
  function automatic led_req_t rand_req(req_t kind);
    led_req_t q;
    q = make_req(kind, $urandom_range(0, 255), $urandom_range(0, 127),
                 $urandom_range(0, 127), $urandom_range(0, 127), $urandom_range(0, 511));
    if (kind inside {REQ_RGB, REQ_WHEEL}) begin
      if ($urandom_range(0, 9) != 0) q.pixel_index = IDX_W'($urandom_range(0, NUM_LEDS - 1));
      if ($urandom_range(0, 6) != 0) q.wheel_pos = WHEEL_W'($urandom_range(0, 383));
    end
    return q;
  endfunction

  // Append a request and track whether a frame is streaming.
  task automatic plan_req(led_req_t q);
    req_plan.push_back(q);
    case (q.kind)
      REQ_SHOW: begin
        if (!plan_active) begin
          plan_active = 1'b1;
          plan_left   = FRAME_BYTES;
        end
      end
      REQ_SLOT: begin
        if (plan_active) begin
          plan_left--;
          if (plan_left == 0) plan_active = 1'b0;
        end
      end
      default: ;
    endcase
  endtask

  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return $urandom_range(1, 2);
    if (roll < 92) return $urandom_range(3, 8);
    return $urandom_range(20, 60);
  endfunction

  task automatic build_plan();
    led_req_t q;
    int       n;
    bit       first_phase;
    // Directed: slot while idle, strip edges, out-of-range indices, every
    // wheel band edge plus the black range, then show and ignored traffic
    // while the frame streams.
    plan_req(make_req(REQ_SLOT, 0, 0, 0, 0, 0));
    plan_req(make_req(REQ_RGB, 0, 127, 127, 127, 0));
    plan_req(make_req(REQ_RGB, NUM_LEDS - 1, 0, 0, 0, 0));
    plan_req(make_req(REQ_RGB, NUM_LEDS, 127, 127, 127, 511));
    plan_req(make_req(REQ_RGB, 255, 127, 127, 127, 511));
    plan_req(make_req(REQ_RGB, 1, 'h55, 'h2a, 'h7f, 'h1aa));
    plan_req(make_req(REQ_WHEEL, 2, 0, 0, 0, 0));
    plan_req(make_req(REQ_WHEEL, 3, 0, 0, 0, 127));
    plan_req(make_req(REQ_WHEEL, 4, 0, 0, 0, 128));
    plan_req(make_req(REQ_WHEEL, 5, 0, 0, 0, 255));
    plan_req(make_req(REQ_WHEEL, 6, 0, 0, 0, 256));
    plan_req(make_req(REQ_WHEEL, 7, 127, 127, 127, 383));
    plan_req(make_req(REQ_WHEEL, 8, 127, 127, 127, 384));
    plan_req(make_req(REQ_WHEEL, 9, 127, 127, 127, 511));
    plan_req(make_req(REQ_SHOW, 0, 0, 0, 0, 0));
    plan_req(make_req(REQ_SLOT, 255, 127, 127, 127, 511));
    plan_req(make_req(REQ_SHOW, 0, 0, 0, 0, 0));
    plan_req(make_req(REQ_RGB, 0, 0, 0, 0, 0));
    plan_req(make_req(REQ_WHEEL, 1, 0, 0, 0, 200));
    while (plan_active) plan_req(rand_req(REQ_SLOT));

    // Random frames: writes and idle slots, a show, then the full run of
    // slots with ignored writes and shows sprinkled in. Stop adding frames
    // once the plan is within half a frame of the item count.
    first_phase = 1'b1;
    while (req_plan.size() + FRAME_BYTES / 2 < ITEMS_TARGET) begin
      n = $urandom_range(0, 40);
      repeat (n) begin
        if ($urandom_range(0, 4) == 0) plan_req(rand_req(REQ_SLOT));
        else plan_req(rand_req($urandom_range(0, 1) ? REQ_RGB : REQ_WHEEL));
      end
      q = rand_req(REQ_SHOW);
      q.drain = first_phase || ($urandom_range(0, 2) == 0);
      plan_req(q);
      first_phase = 1'b0;
      while (plan_active) begin
        if ($urandom_range(0, 99) < 8) begin
          case ($urandom_range(0, 2))
            0:       plan_req(rand_req(REQ_RGB));
            1:       plan_req(rand_req(REQ_WHEEL));
            default: plan_req(rand_req(REQ_SHOW));
          endcase
        end else begin
          plan_req(rand_req(REQ_SLOT));
        end
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Request driver: pop the plan, hold each request until its transfer, and
  // insert random gaps with occasional gap-free bursts.
  // --------------------------------------------------------------------------
  int unsigned send_gap;
  int unsigned send_burst;

  always @(posedge clk) begin : drive_requests
    led_req_t    nxt;
    int unsigned roll;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      send_gap    <= 0;
      send_burst  <= 0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (send_gap != 0) begin
        in_ch.valid <= 1'b0;
        send_gap    <= send_gap - 1;
      end else if (req_plan.size() == 0 ||
                   (req_plan[0].drain && (in_ch.valid || pending_bytes.size() != 0))) begin
        // Hold off: nothing left, or a drain point waiting for the stream
        // to empty (valid drops first so the last transfer is predicted).
        in_ch.valid <= 1'b0;
      end else begin
        nxt = req_plan.pop_front();
        in_ch.valid       <= 1'b1;
        in_ch.req_type    <= nxt.kind;
        in_ch.pixel_index <= nxt.pixel_index;
        in_ch.red         <= nxt.red;
        in_ch.green       <= nxt.green;
        in_ch.blue        <= nxt.blue;
        in_ch.wheel_pos   <= nxt.wheel_pos;
        roll = $urandom_range(0, 99);
        if (send_burst != 0) begin
          send_burst <= send_burst - 1;
        end else if (roll < 3) begin
          send_burst <= $urandom_range(30, 150);
        end else if (roll >= 55) begin
          send_gap <= pick_gap();
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result ready: random stalls, gap-free bursts, and one long hold-off once
  // a hundred bytes have streamed so the block backs up into the request
  // channel while slots keep coming.
  // --------------------------------------------------------------------------
  int unsigned sink_hold;
  int unsigned sink_burst;
  bit          long_hold_done;

  always @(posedge clk) begin : drive_ready
    int unsigned roll;
    if (!rst_n) begin
      out_ch.ready   <= 1'b0;
      sink_hold      <= 0;
      sink_burst     <= 0;
      long_hold_done <= 1'b0;
    end else if (sink_hold != 0) begin
      out_ch.ready <= 1'b0;
      sink_hold    <= sink_hold - 1;
    end else if (!long_hold_done && bytes_checked >= HOLD_AT_BYTES) begin
      out_ch.ready   <= 1'b0;
      sink_hold      <= LONG_HOLD;
      long_hold_done <= 1'b1;
    end else if (sink_burst != 0) begin
      out_ch.ready <= 1'b1;
      sink_burst   <= sink_burst - 1;
    end else begin
      roll = $urandom_range(0, 99);
      if (roll < 4) begin
        out_ch.ready <= 1'b1;
        sink_burst   <= $urandom_range(30, 150);
      end else if (roll < 60) begin
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= 1'b0;
        sink_hold    <= pick_gap();
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: predict from each request transfer first, then check each byte
  // transfer against the oldest owed byte.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : watch_channels
    led_req_t    seen;
    strip_byte_t got;
    if (!rst_n) begin
      foreach (strip_mem[i]) strip_mem[i] = '0;
      frame_pos    = 0;
      frame_active = 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        seen = make_req(req_t'(in_ch.req_type), int'(in_ch.pixel_index), int'(in_ch.red),
                        int'(in_ch.green), int'(in_ch.blue), int'(in_ch.wheel_pos));
        advance_strip(seen);
      end
      if (out_ch.valid && out_ch.ready) begin
        got = '{spi_byte: out_ch.spi_byte, frame_last: out_ch.frame_last};
        bytes_checked++;
        if (pending_bytes.size() == 0) flag_mismatch("unexpected transfer", '0, got);
        else if (got !== pending_bytes[0]) flag_mismatch("wrong value", pending_bytes[0], got);
        if (pending_bytes.size() != 0) void'(pending_bytes.pop_front());
      end
    end
  end

  // --------------------------------------------------------------------------
  // Run control: reset, plan, wait for the stream to drain under a stall
  // watchdog, wait out a tail for stray bytes, then judge.
  // --------------------------------------------------------------------------
  initial begin : run_control
    int stall_cycles;
    bit timed_out;
    rst_n             = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.req_type    = '0;
    in_ch.pixel_index = '0;
    in_ch.red         = '0;
    in_ch.green       = '0;
    in_ch.blue        = '0;
    in_ch.wheel_pos   = '0;
    out_ch.ready      = 1'b0;
    bytes_checked     = 0;
    mismatch_count    = 0;
    plan_active       = 1'b0;
    plan_left         = 0;
    stall_cycles      = 0;
    timed_out         = 1'b0;
    build_plan();

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Advance until every request is sent and every owed byte has arrived.
    @(posedge clk);
    while (!timed_out &&
           (req_plan.size() != 0 || in_ch.valid || pending_bytes.size() != 0)) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) timed_out = 1'b1;
    end

    if (!timed_out) repeat (TAIL_CYCLES) @(posedge clk);
    if (!timed_out && mismatch_count == 0 && pending_bytes.size() == 0) begin
      $display("PASS led_strip_frame_streamer_unit");
    end else begin
      $display("FAIL led_strip_frame_streamer_unit");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+rtl/core
rtl/core/lsfs_pkg.sv
rtl/core/lsfs_if.sv
rtl/core/led_strip_frame_streamer_unit.sv
tb/sv/tb.sv
